>>> rtl/core/cfp_pkg.sv
// Shared constants and the CRC-8 byte update for the framed packet parser.
// No dependencies.
`default_nettype none

package cfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] TYPE_PONG   = 8'h23;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] PONG_MIN_LEN = 8'd3;

  localparam int SUM_W   = 48;
  localparam int COUNT_W = 32;
  localparam int LAT_W   = 16;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_OTHER    = 2'd2,
    ST_FOREIGN  = 2'd3
  } frame_status_t;

  // CRC-8, MSB first, no reflection, no final xor; one byte per call
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cfp_byte_if.sv
// Valid/ready channel carrying one received stream byte per transfer.
// No dependencies.
`default_nettype none

interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cfp_result_if.sv
// Valid/ready channel carrying one frame report per transfer.
// Depends on cfp_pkg for field widths.
`default_nettype none

interface cfp_result_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  frame_status;
  logic [7:0]                  frame_type;
  logic [7:0]                  sender_id;
  logic [cfp_pkg::LAT_W-1:0]   latency_us;
  logic [cfp_pkg::LAT_W-1:0]   min_us;
  logic [cfp_pkg::LAT_W-1:0]   max_us;
  logic [cfp_pkg::SUM_W-1:0]   sum_us;
  logic [cfp_pkg::COUNT_W-1:0] sample_count;

  modport source (output valid, output frame_status, output frame_type, output sender_id,
                  output latency_us, output min_us, output max_us, output sum_us,
                  output sample_count, input ready);
  modport sink   (input valid, input frame_status, input frame_type, input sender_id,
                  input latency_us, input min_us, input max_us, input sum_us,
                  input sample_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/crc8_frame_parser_latency_stats_top.sv
// Framed packet parser with CRC-8 check and pong latency statistics.
// Depends on cfp_pkg, cfp_byte_if, cfp_result_if.
// One byte per cycle unless stalled; each byte is fully handled in its transfer cycle.
// A frame report enters the output register in the cycle after its CRC byte transfers.
// A CRC byte stalls only while the previous report is still waiting in the output register.
// Reset (rst, synchronous, active high): hunting for sync, statistics and target cleared.
`default_nettype none

module crc8_frame_parser_latency_stats_top (
  input  wire logic       clk,
  input  wire logic       rst,
  cfp_byte_if.sink        rx,
  cfp_result_if.source    report,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_t;

  phase_t                       phase;
  logic [7:0]                   target_robot;
  logic [7:0]                   frame_type_reg;
  logic [7:0]                   payload_length;
  logic [7:0]                   payload_index;
  logic [7:0]                   running_crc;
  logic [7:0]                   captured_id;
  logic [cfp_pkg::LAT_W-1:0]    captured_latency;
  logic [cfp_pkg::LAT_W-1:0]    latest_latency;
  logic [cfp_pkg::LAT_W-1:0]    min_latency;
  logic [cfp_pkg::LAT_W-1:0]    max_latency;
  logic [cfp_pkg::SUM_W-1:0]    latency_sum;
  logic [cfp_pkg::COUNT_W-1:0]  latency_count;
  logic                         out_valid;

  logic                         accept;
  logic [7:0]                   b;
  logic [7:0]                   crc_next;
  logic [7:0]                   index_next;
  cfp_pkg::frame_status_t       status;
  logic                         take_sample;
  logic [cfp_pkg::LAT_W-1:0]    latest_next;
  logic [cfp_pkg::LAT_W-1:0]    min_next;
  logic [cfp_pkg::LAT_W-1:0]    max_next;
  logic [cfp_pkg::SUM_W:0]      sum_wide;
  logic [cfp_pkg::SUM_W-1:0]    sum_next;
  logic [cfp_pkg::COUNT_W-1:0]  count_next;

  // only the CRC byte produces a report, so only it needs room downstream
  assign rx.ready = (phase != PH_CRC) || !out_valid || report.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  assign crc_next   = cfp_pkg::crc8_byte((phase == PH_TYPE) ? 8'd0 : running_crc, b);
  assign index_next = payload_index + 8'd1;

  always_comb begin
    priority if (b != running_crc) begin
      status = cfp_pkg::ST_CRC_BAD;
    end else if (frame_type_reg != cfp_pkg::TYPE_PONG ||
                 payload_length < cfp_pkg::PONG_MIN_LEN) begin
      status = cfp_pkg::ST_OTHER;
    end else if (captured_id != target_robot) begin
      status = cfp_pkg::ST_FOREIGN;
    end else begin
      status = cfp_pkg::ST_COUNTED;
    end
  end

  assign take_sample = (status == cfp_pkg::ST_COUNTED);
  assign sum_wide    = {1'b0, latency_sum} +
                       {{(cfp_pkg::SUM_W + 1 - cfp_pkg::LAT_W){1'b0}}, captured_latency};

  always_comb begin
    latest_next = latest_latency;
    min_next    = min_latency;
    max_next    = max_latency;
    sum_next    = latency_sum;
    count_next  = latency_count;
    if (take_sample) begin
      latest_next = captured_latency;
      if (captured_latency < min_latency) begin
        min_next = captured_latency;
      end
      if (captured_latency > max_latency) begin
        max_next = captured_latency;
      end
      sum_next = sum_wide[cfp_pkg::SUM_W] ? {cfp_pkg::SUM_W{1'b1}}
                                          : sum_wide[cfp_pkg::SUM_W-1:0];
      if (latency_count != {cfp_pkg::COUNT_W{1'b1}}) begin
        count_next = latency_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT0;
      target_robot     <= '0;
      frame_type_reg   <= '0;
      payload_length   <= '0;
      payload_index    <= '0;
      running_crc      <= '0;
      captured_id      <= '0;
      captured_latency <= '0;
      latest_latency   <= '0;
      min_latency      <= {cfp_pkg::LAT_W{1'b1}};
      max_latency      <= '0;
      latency_sum      <= '0;
      latency_count    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_robot <= cfg_wdata;
      end
      if (report.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        unique case (phase)
          PH_HUNT0: begin
            if (b == cfp_pkg::SYNC_FIRST) begin
              phase <= PH_HUNT1;
            end
          end
          PH_HUNT1: begin
            // a repeated first sync byte keeps the hunt armed
            if (b == cfp_pkg::SYNC_SECOND) begin
              phase <= PH_TYPE;
            end else if (b != cfp_pkg::SYNC_FIRST) begin
              phase <= PH_HUNT0;
            end
          end
          PH_TYPE: begin
            frame_type_reg   <= b;
            running_crc      <= crc_next;
            captured_id      <= '0;
            captured_latency <= '0;
            phase            <= PH_LEN;
          end
          PH_LEN: begin
            payload_length <= b;
            payload_index  <= '0;
            running_crc    <= crc_next;
            phase          <= (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (payload_index == 8'd0) begin
              captured_id <= b;
            end else if (payload_index == 8'd1) begin
              captured_latency[7:0] <= b;
            end else if (payload_index == 8'd2) begin
              captured_latency[15:8] <= b;
            end
            running_crc   <= crc_next;
            payload_index <= index_next;
            if (index_next >= payload_length) begin
              phase <= PH_CRC;
            end
          end
          PH_CRC: begin
            latest_latency      <= latest_next;
            min_latency         <= min_next;
            max_latency         <= max_next;
            latency_sum         <= sum_next;
            latency_count       <= count_next;
            out_valid           <= 1'b1;
            report.frame_status <= status;
            report.frame_type   <= frame_type_reg;
            report.sender_id    <= (payload_length == 8'd0) ? 8'd0 : captured_id;
            report.latency_us   <= latest_next;
            report.min_us       <= min_next;
            report.max_us       <= max_next;
            report.sum_us       <= sum_next;
            report.sample_count <= count_next;
            phase               <= PH_HUNT0;
          end
          default: begin
            phase <= PH_HUNT0;
          end
        endcase
      end
    end
  end

  assign report.valid = out_valid;

endmodule

`default_nettype wire

>>> verif/cfp_frame_checker.sv
`timescale 1ns / 100ps
// Frame report checker: watches the byte and report channels, predicts each report.
// Depends on cfp_pkg, cfp_byte_if and cfp_result_if.

module cfp_frame_checker
  import cfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  cfp_byte_if             rx,
  cfp_result_if           report,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output int              fail_count,
  output int              pending,
  output int              frames_checked,
  output int              counted_frames,
  output int              crc_bad_frames,
  output int              other_frames,
  output int              foreign_frames
);

  typedef enum logic [2:0] {
    SEEK_AA,
    SEEK_55,
    GET_TYPE,
    GET_LEN,
    GET_BODY,
    GET_CRC
  } parse_phase_t;

  typedef struct packed {
    frame_status_t      status;
    logic [7:0]         ftype;
    logic [7:0]         rid;
    logic [LAT_W-1:0]   latest;
    logic [LAT_W-1:0]   lat_min;
    logic [LAT_W-1:0]   lat_max;
    logic [SUM_W-1:0]   lat_sum;
    logic [COUNT_W-1:0] lat_count;
  } frame_report_t;

  frame_report_t expected_reports[$];

  parse_phase_t       phase;
  logic [7:0]         target;
  logic [7:0]         cur_type;
  logic [7:0]         body_len;
  logic [7:0]         body_idx;
  logic [7:0]         crc;
  logic [7:0]         cap_id;
  logic [LAT_W-1:0]   cap_lat;
  logic [LAT_W-1:0]   latest;
  logic [LAT_W-1:0]   lat_min;
  logic [LAT_W-1:0]   lat_max;
  logic [SUM_W-1:0]   lat_sum;
  logic [COUNT_W-1:0] lat_count;

  int mismatches = 0;
  int checked    = 0;
  int tally[4]   = '{0, 0, 0, 0};

  // bit-serial form, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] cur, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = cur;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want_val);
    $display("[%0t] report mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got,
             want_val);
    mismatches++;
  endtask

  always @(posedge clk) begin : predict_and_compare
    frame_report_t    want;
    frame_status_t    st;
    logic [SUM_W:0]   wide_sum;
    logic [7:0]       b;
    if (rst) begin
      phase     = SEEK_AA;
      target    = 8'h00;
      cur_type  = 8'h00;
      body_len  = 8'h00;
      body_idx  = 8'h00;
      crc       = 8'h00;
      cap_id    = 8'h00;
      cap_lat   = '0;
      latest    = '0;
      lat_min   = '1;
      lat_max   = '0;
      lat_sum   = '0;
      lat_count = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) target = cfg_wdata;

      if (report.valid && report.ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected report, status", 64'(report.frame_status), 64'h0);
        end else begin
          want = expected_reports[0];
          expected_reports.delete(0);
          if (report.frame_status !== want.status)
            flag_mismatch("frame_status", 64'(report.frame_status), 64'(want.status));
          if (report.frame_type !== want.ftype)
            flag_mismatch("frame_type", 64'(report.frame_type), 64'(want.ftype));
          if (report.sender_id !== want.rid)
            flag_mismatch("sender_id", 64'(report.sender_id), 64'(want.rid));
          if (report.latency_us !== want.latest)
            flag_mismatch("latency_us", 64'(report.latency_us), 64'(want.latest));
          if (report.min_us !== want.lat_min)
            flag_mismatch("min_us", 64'(report.min_us), 64'(want.lat_min));
          if (report.max_us !== want.lat_max)
            flag_mismatch("max_us", 64'(report.max_us), 64'(want.lat_max));
          if (report.sum_us !== want.lat_sum)
            flag_mismatch("sum_us", 64'(report.sum_us), 64'(want.lat_sum));
          if (report.sample_count !== want.lat_count)
            flag_mismatch("sample_count", 64'(report.sample_count), 64'(want.lat_count));
          tally[want.status]++;
          checked++;
        end
      end

      if (rx.valid && rx.ready) begin
        b = rx.rx_byte;
        case (phase)
          SEEK_AA: begin
            if (b == SYNC_FIRST) phase = SEEK_55;
          end
          SEEK_55: begin
            // a repeated 0xAA keeps the hunt armed
            if (b == SYNC_SECOND) phase = GET_TYPE;
            else if (b != SYNC_FIRST) phase = SEEK_AA;
          end
          GET_TYPE: begin
            cur_type = b;
            crc      = crc8_next(8'h00, b);
            cap_id   = 8'h00;
            cap_lat  = '0;
            phase    = GET_LEN;
          end
          GET_LEN: begin
            body_len = b;
            body_idx = 8'h00;
            crc      = crc8_next(crc, b);
            phase    = (b == 8'h00) ? GET_CRC : GET_BODY;
          end
          GET_BODY: begin
            if (body_idx == 8'd0) cap_id = b;
            else if (body_idx == 8'd1) cap_lat[7:0] = b;
            else if (body_idx == 8'd2) cap_lat[15:8] = b;
            crc      = crc8_next(crc, b);
            body_idx = body_idx + 8'd1;
            if (body_idx >= body_len) phase = GET_CRC;
          end
          GET_CRC: begin
            if (b != crc) begin
              st = ST_CRC_BAD;
            end else if (cur_type != TYPE_PONG || body_len < PONG_MIN_LEN) begin
              st = ST_OTHER;
            end else if (cap_id != target) begin
              st = ST_FOREIGN;
            end else begin
              st     = ST_COUNTED;
              latest = cap_lat;
              if (cap_lat < lat_min) lat_min = cap_lat;
              if (cap_lat > lat_max) lat_max = cap_lat;
              wide_sum = {1'b0, lat_sum} + cap_lat;
              lat_sum  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
              if (lat_count != '1) lat_count = lat_count + 1'b1;
            end
            want.status    = st;
            want.ftype     = cur_type;
            want.rid       = (body_len == 8'h00) ? 8'h00 : cap_id;
            want.latest    = latest;
            want.lat_min   = lat_min;
            want.lat_max   = lat_max;
            want.lat_sum   = lat_sum;
            want.lat_count = lat_count;
            expected_reports = {expected_reports, want};
            phase = SEEK_AA;
          end
          default: phase = SEEK_AA;
        endcase
      end
    end

    fail_count     <= mismatches;
    pending        <= expected_reports.size();
    frames_checked <= checked;
    counted_frames <= tally[ST_COUNTED];
    crc_bad_frames <= tally[ST_CRC_BAD];
    other_frames   <= tally[ST_OTHER];
    foreign_frames <= tally[ST_FOREIGN];
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives framed byte traffic and the target register, gives the verdict.
// Depends on cfp_pkg, cfp_byte_if, cfp_result_if, cfp_frame_checker and the parser top.

module tb_top;
  import cfp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 360;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  cfp_byte_if   byte_ch();
  cfp_result_if report_ch();

  int fail_count;
  int pending;
  int frames_checked;
  int counted_frames;
  int crc_bad_frames;
  int other_frames;
  int foreign_frames;

  bit idle_on;
  bit hold_req;
  int quiet_cycles = 0;
  int stream_bytes = 0;
  int frame_bytes  = 0;

  crc8_frame_parser_latency_stats_top dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (byte_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cfp_frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .rx             (byte_ch),
    .report         (report_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_checked (frames_checked),
    .counted_frames (counted_frames),
    .crc_bad_frames (crc_bad_frames),
    .other_frames   (other_frames),
    .foreign_frames (foreign_frames)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // report sink: random back-pressure plus one long hold-off
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        report_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        report_ch.ready <= !(idle_on && $urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 18) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    stream_bytes++;
  endtask

  // payload: robot id, latency low, latency high, then filler
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
                            input logic [7:0] rid, input logic [15:0] lat,
                            input bit good_crc, input bit sync_fill);
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'h00;
    put_byte(SYNC_FIRST);
    put_byte(SYNC_SECOND);
    put_byte(ftype);
    crc = crc8_byte(crc, ftype);
    put_byte(len);
    crc = crc8_byte(crc, len);
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = rid;
      else if (i == 1) b = lat[7:0];
      else if (i == 2) b = lat[15:8];
      else if (sync_fill) b = i[0] ? SYNC_FIRST : SYNC_SECOND;
      else b = 8'($urandom);
      put_byte(b);
      crc = crc8_byte(crc, b);
    end
    put_byte(good_crc ? crc : crc ^ 8'($urandom_range(255, 1)));
    frame_bytes += len + 5;
  endtask

  task automatic random_traffic(input logic [7:0] target);
    int         pick;
    logic [7:0] b;
    logic [7:0] ftype;
    logic [7:0] len;
    logic [7:0] rid;
    logic [15:0] lat;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // line noise, never a first sync byte (0xAA)
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom);
        if (b == SYNC_FIRST) b = 8'h00;
        put_byte(b);
      end
    end else if (pick < 9) begin
      // broken sync pair
      b = 8'($urandom);
      if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'h3C;
      put_byte(SYNC_FIRST);
      put_byte(b);
    end else begin
      ftype = ($urandom_range(99) < 65) ? TYPE_PONG : 8'($urandom);
      pick  = $urandom_range(99);
      if (pick < 80) len = 8'($urandom_range(8, 3));
      else if (pick < 92) len = 8'($urandom_range(2, 0));
      else if (pick < 99) len = 8'($urandom_range(40, 9));
      else len = 8'hFF;
      rid  = ($urandom_range(99) < 70) ? target : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) lat = 16'h0000;
      else if (pick < 20) lat = 16'hFFFF;
      else lat = 16'($urandom);
      if ($urandom_range(99) < 10) put_byte(SYNC_FIRST);
      send_frame(ftype, len, rid, lat, $urandom_range(99) < 85, $urandom_range(99) < 5);
    end
  endtask

  task automatic wait_drained();
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] targets[5];
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 8'h00;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    idle_on         <= 1'b1;
    hold_req        <= 1'b0;
    targets = '{8'h00, 8'hFF, 8'($urandom), 8'h80, 8'($urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames, target still at its reset value
    put_byte(SYNC_FIRST);
    put_byte(SYNC_FIRST);
    send_frame(TYPE_PONG, 8'd3, 8'h00, 16'hFFFF, 1'b1, 1'b0);
    send_frame(TYPE_PONG, 8'd3, 8'h00, 16'h0000, 1'b1, 1'b0);
    put_byte(SYNC_FIRST);
    put_byte(8'h12);
    send_frame(8'hFF, 8'd0, 8'h77, 16'h0000, 1'b1, 1'b0);
    send_frame(TYPE_PONG, 8'd4, 8'hFF, 16'h1234, 1'b1, 1'b0);
    send_frame(TYPE_PONG, 8'd2, 8'h00, 16'h5678, 1'b1, 1'b0);
    // bad CRC with a sync pair inside the payload
    send_frame(TYPE_PONG, 8'd7, 8'h00, 16'h0101, 1'b0, 1'b1);
    send_frame(8'h00, 8'd1, 8'h00, 16'h0000, 1'b1, 1'b0);

    foreach (targets[p]) begin
      byte_ch.valid <= 1'b0;
      wait_drained();
      cfg_we    <= 1'b1;
      cfg_wdata <= targets[p];
      @(posedge clk);
      cfg_we   <= 1'b0;
      idle_on  <= (p != 2);
      hold_req <= (p >= 3);
      frame_bytes = 0;
      while (frame_bytes < PHASE_BYTES) random_traffic(targets[p]);
    end

    byte_ch.valid <= 1'b0;
    wait_drained();
    $display("%0d stream bytes sent, %0d frame reports checked over 5 target settings",
             stream_bytes, frames_checked);
    $display("reports: %0d counted pongs, %0d crc errors, %0d other/short, %0d foreign robot",
             counted_frames, crc_bad_frames, other_frames, foreign_frames);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cfp_pkg.sv
rtl/core/cfp_byte_if.sv
rtl/core/cfp_result_if.sv
rtl/core/crc8_frame_parser_latency_stats_top.sv
verif/cfp_frame_checker.sv
verif/tb_top.sv
